// ===== rtl/bale_pkg.sv =====
// Package for the bounded array list engine.
// Holds the capacity constants, opcode and status codes, and the item types.
// Used by every module in the rtl folder; depends on nothing.
package bale_pkg;

   // Number of entries the list can hold; legal range 2 to 64.
   localparam int CAPACITY = 32;
   // Live count holds 0 to CAPACITY; an entry address holds 0 to CAPACITY-1.
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);

   // Fixed field widths of the request and response items.
   localparam int DATA_W    = 32;
   localparam int POS_W     = 7;
   localparam int CNT_OUT_W = 7;
   localparam int IDX_OUT_W = 6;

   typedef enum logic [2:0] {
      OP_CLEAR   = 3'd0,
      OP_APPEND  = 3'd1,
      OP_INS_POS = 3'd2,
      OP_DEL_POS = 3'd3,
      OP_ORD_INS = 3'd4,
      OP_DEL_VAL = 3'd5,
      OP_DUMP    = 3'd6
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_POS   = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      opcode_type                opcode;
      logic [POS_W-1:0]          position;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [CNT_OUT_W-1:0]      count;
      logic [IDX_OUT_W-1:0]      index;
      logic signed [DATA_W-1:0]  element;
      logic                      last;
   } rsp_type;

   // Access to the entry memory: one read port and one write port.
   typedef struct packed {
      logic                      rd_en;
      logic [IDX_W-1:0]          rd_addr;
      logic                      wr_en;
      logic [IDX_W-1:0]          wr_addr;
      logic signed [DATA_W-1:0]  wr_data;
   } mem_req_type;

   // Outcome of the shared compare unit.
   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_RD,
      S_INS_WR,
      S_DEL_RD,
      S_DEL_WR,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DUMP_RD,
      S_DUMP_OUT,
      S_RESULT
   } state_type;

endpackage

// ===== rtl/bale_mem.sv =====
// Entry storage of the list: CAPACITY words, one write and one read per cycle.
// The read data is registered. Depends on bale_pkg.
module bale_mem
   import bale_pkg::*;
(
   input  logic                      clock,
   input  mem_req_type               mem_req,
   output logic signed [DATA_W-1:0]  rd_data
);

   logic signed [DATA_W-1:0] mem [CAPACITY];
   logic signed [DATA_W-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bale_cmp.sv =====
// Shared compare unit of the list engine: signed greater-than and equality
// of the entry just read against the request value. Depends on bale_pkg.
module bale_cmp
   import bale_pkg::*;
(
   input  logic signed [DATA_W-1:0] entry,
   input  logic signed [DATA_W-1:0] value,
   output cmp_type                  result
);

   // One magnitude compare serves the ordered insert and one equality check the delete by value.
   always_comb begin
      result.gt = entry > value;
      result.eq = entry == value;
   end

endmodule

// ===== rtl/bale_seq.sv =====
// Sequencer of the list engine: decodes a request, checks it, and steps
// through the entry memory one entry at a time using the shared compare unit.
// Depends on bale_pkg and bale_cmp.
module bale_seq
   import bale_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  req_type                   req_item,
   output logic                      req_ready,
   input  logic                      slot_free,
   output logic                      push,
   output rsp_type                   push_item,
   output mem_req_type               mem_req,
   input  logic signed [DATA_W-1:0]  rd_data
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  stop_ff, stop_in;
   logic              ordered_ff, ordered_in;
   status_type        status_ff, status_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   req_type           cur_ff, cur_in;
   cmp_type           cmp;

   bale_cmp u_cmp (
      .entry  (rd_data),
      .value  (cur_ff.value),
      .result (cmp)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      stop_ff    <= stop_in;
      ordered_ff <= ordered_in;
      status_ff  <= status_in;
      index_ff   <= index_in;
      cur_ff     <= cur_in;
   end

   // Next state, memory access and result push.
   always_comb begin
      logic [POS_W-1:0] cnt_pos;
      logic [CNT_W:0]   ptr_next;
      logic             at_end;

      cnt_pos  = POS_W'(count_ff);
      ptr_next = {1'b0, ptr_ff} + 1'b1;
      at_end   = ptr_next >= {1'b0, count_ff};

      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      stop_in    = stop_ff;
      ordered_in = ordered_ff;
      status_in  = status_ff;
      index_in   = index_ff;
      cur_in     = cur_ff;
      req_ready  = 1'b0;
      push       = 1'b0;
      push_item  = '0;
      mem_req    = '0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cur_in   = req_item;
               state_in = S_DECODE;
            end
         end

         // Check the request against the live count and set up the walk.
         S_DECODE: begin
            status_in = ST_OK;
            index_in  = '0;
            ptr_in    = count_ff;
            state_in  = S_RESULT;
            case (cur_ff.opcode)
               OP_CLEAR: begin
                  count_in = '0;
               end
               OP_APPEND, OP_INS_POS, OP_ORD_INS: begin
                  ordered_in = cur_ff.opcode == OP_ORD_INS;
                  stop_in    = (cur_ff.opcode == OP_INS_POS) ?
                               CNT_W'(cur_ff.position - 1'b1) :
                               (cur_ff.opcode == OP_APPEND) ? count_ff : '0;
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else if (cur_ff.opcode == OP_INS_POS &&
                               (cur_ff.position == '0 ||
                                cur_ff.position > cnt_pos + 1'b1)) begin
                     status_in = ST_BAD_POS;
                  end else begin
                     state_in = S_INS_RD;
                  end
               end
               OP_DEL_POS: begin
                  ptr_in   = CNT_W'(cur_ff.position - 1'b1);
                  index_in = IDX_W'(cur_ff.position - 1'b1);
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     index_in  = '0;
                  end else if (cur_ff.position == '0 || cur_ff.position > cnt_pos) begin
                     status_in = ST_BAD_POS;
                     index_in  = '0;
                  end else begin
                     state_in = S_DEL_RD;
                  end
               end
               OP_DEL_VAL: begin
                  ptr_in = '0;
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     state_in = S_SRCH_RD;
                  end
               end
               OP_DUMP: begin
                  ptr_in = '0;
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     state_in = S_DUMP_RD;
                  end
               end
               default: begin
               end
            endcase
         end

         // Insert: move entries up one place until the slot is reached.
         S_INS_RD: begin
            if (ptr_ff == stop_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = ptr_ff[IDX_W-1:0];
               mem_req.wr_data = cur_ff.value;
               count_in        = count_ff + 1'b1;
               state_in        = S_RESULT;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = IDX_W'(ptr_ff - 1'b1);
               state_in        = S_INS_WR;
            end
         end

         S_INS_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_ff[IDX_W-1:0];
            if (ordered_ff && !cmp.gt) begin
               mem_req.wr_data = cur_ff.value;
               count_in        = count_ff + 1'b1;
               state_in        = S_RESULT;
            end else begin
               mem_req.wr_data = rd_data;
               ptr_in          = ptr_ff - 1'b1;
               state_in        = S_INS_RD;
            end
         end

         // Delete: move entries down one place from the removed slot.
         S_DEL_RD: begin
            if (at_end) begin
               count_in = count_ff - 1'b1;
               state_in = S_RESULT;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptr_next[IDX_W-1:0];
               state_in        = S_DEL_WR;
            end
         end

         S_DEL_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_ff[IDX_W-1:0];
            mem_req.wr_data = rd_data;
            ptr_in          = ptr_next[CNT_W-1:0];
            state_in        = S_DEL_RD;
         end

         // Search for the first entry equal to the value.
         S_SRCH_RD: begin
            if (ptr_ff == count_ff) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESULT;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptr_ff[IDX_W-1:0];
               state_in        = S_SRCH_CMP;
            end
         end

         S_SRCH_CMP: begin
            if (cmp.eq) begin
               index_in = ptr_ff[IDX_W-1:0];
               state_in = S_DEL_RD;
            end else begin
               ptr_in   = ptr_next[CNT_W-1:0];
               state_in = S_SRCH_RD;
            end
         end

         // Dump: read each entry and hand it out as one item.
         S_DUMP_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ptr_ff[IDX_W-1:0];
            state_in        = S_DUMP_OUT;
         end

         S_DUMP_OUT: begin
            if (slot_free) begin
               push              = 1'b1;
               push_item.status  = ST_OK;
               push_item.count   = CNT_OUT_W'(count_ff);
               push_item.index   = IDX_OUT_W'(ptr_ff);
               push_item.element = rd_data;
               push_item.last    = at_end;
               ptr_in            = ptr_next[CNT_W-1:0];
               state_in          = at_end ? S_IDLE : S_DUMP_RD;
            end
         end

         // Single closing item of every other request.
         S_RESULT: begin
            if (slot_free) begin
               push             = 1'b1;
               push_item.status = status_ff;
               push_item.count  = CNT_OUT_W'(count_ff);
               push_item.index  = IDX_OUT_W'(index_ff);
               push_item.last   = 1'b1;
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/bounded_array_list_engine.sv =====
// Top level of the bounded array list engine.
// Instantiates the sequencer and the entry memory and holds the output register.
// Depends on bale_pkg, bale_seq and bale_mem.
//
// Usage:
//   The req channel carries one request item (opcode, position, value) under a
//   valid/ready handshake; the rsp channel returns result items (status, count,
//   index, element, last) the same way. Every request gives one result item,
//   except a dump of a non-empty list, which gives one item per entry in index
//   order with last set on the final one.
//   The block works on one request at a time and drops req_ready from the cycle
//   after acceptance until the request's final item is in the output register,
//   so it cannot take a new request before it is through with the last one.
//   Timing is set by the walk over the entry memory, whose read is registered:
//   a rejected request, a clear or an unused opcode goes from decode straight
//   to the result; an insert or delete moves each entry with a read state and a
//   write state; an ordered insert stops on the first entry not greater than
//   its value; a delete by value first searches from index 0 with a read and a
//   compare state per entry; a dump reads each entry before it hands it out.
//   A stalled rsp_ready holds the current item in the output register and the
//   sequencer waits; the next item is loaded in the cycle the held one leaves.
//   Reset empties the list and the output register; entry contents are not
//   cleared, since no operation reads past the live count.
module bounded_array_list_engine
   import bale_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_item
);

   mem_req_type               mem_req;
   logic signed [DATA_W-1:0]  rd_data;
   logic                      slot_free;
   logic                      push;
   rsp_type                   push_item;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_item_ff, rsp_item_in;

   bale_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_ready (req_ready),
      .slot_free (slot_free),
      .push      (push),
      .push_item (push_item),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   bale_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // The output register can take an item when empty or when its item leaves.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = push_item;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
